// ===== hw/rtl/planar_twist_integrator_macros.svh =====
// assertion macros for the planar twist integrator
// needs clk_i and rst_ni in the scope of the module that uses them
`ifndef PLANAR_TWIST_INTEGRATOR_MACROS_SVH
`define PLANAR_TWIST_INTEGRATOR_MACROS_SVH

// same-cycle implication
`define PTI_ASSERT_IMPL(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error("pti: implication check failed");

// implication after a fixed number of cycles
`define PTI_ASSERT_DELAY(lbl, cond, n, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> ##(n) (prop)) \
    else $error("pti: delayed check failed");

`endif

// ===== hw/rtl/pti_pkg.sv =====
// shared constants, tables and stage payload types of the planar twist integrator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pti_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 24;
  localparam int DIV_SHIFT    = 30 - FRAC_BITS;
  localparam int D_W          = 32 + DIV_SHIFT;
  localparam int Q_W          = 33;

  localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
  localparam logic signed [33:0] ONE_X       = 34'sd1073741824;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [30:0]        HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0]        INV_2PI_HI  = 32'h28BE60DB;
  localparam logic [31:0]        INV_2PI_LO  = 32'h9391054A;

  typedef struct packed {
    logic               zero;
    logic               flip;
    logic               w_neg;
    logic [31:0]        abs_w;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } cordic_meta_t;

  typedef struct packed {
    logic               zero;
    logic               neg_x;
    logic               neg_y;
    logic signed [31:0] c;
    logic signed [31:0] s;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } div_meta_t;

  // atan(2^-i) in q2.30
  function automatic logic signed [32:0] arc_of(input int i);
    logic signed [32:0] r;
    case (i)
      0: r = 33'sd843314857;
      1: r = 33'sd497837829;
      2: r = 33'sd263043837;
      3: r = 33'sd133525159;
      4: r = 33'sd67021687;
      5: r = 33'sd33543516;
      6: r = 33'sd16775851;
      7: r = 33'sd8388437;
      8: r = 33'sd4194283;
      9: r = 33'sd2097149;
      default: r = 33'(64'd1 << (30 - i));
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/planar_twist_integrator.sv =====
// planar twist integrator top level: threshold register, pipeline and result register
// depends on pti_pkg, pti_phase, pti_cordic, pti_trans, pti_div and the macro header
//
//   port group       direction  handshake          contents
//   request          in         start_i / busy_o   angular_rate_i, linear_rate_x_i, linear_rate_y_i
//   result           out        done_o (strobe)    cos/sin_heading_o, shift_x/y_o, saturated_o
//   threshold write  in         cfg_we_i           cfg_wdata_i
//
// one request enters per cycle; busy_o stays low
// the pipeline runs through angle reduction, cordic, numerator, divider and output register in that order
// every stage carries a valid bit; nothing waits on the receiver
// reset clears valid bits and the threshold register, payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none

`include "planar_twist_integrator_macros.svh"

module planar_twist_integrator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] angular_rate_i,
  input  logic signed [31:0] linear_rate_x_i,
  input  logic signed [31:0] linear_rate_y_i,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  output logic               done_o,
  output logic signed [31:0] cos_heading_o,
  output logic signed [31:0] sin_heading_o,
  output logic signed [31:0] shift_x_o,
  output logic signed [31:0] shift_y_o,
  output logic               saturated_o
);

  logic [15:0] thr_q;

  logic                  ph_valid;
  logic signed [32:0]    ph_z;
  pti_pkg::cordic_meta_t ph_meta;

  logic                  cor_valid;
  logic signed [33:0]    cor_x, cor_y;
  pti_pkg::cordic_meta_t cor_meta;

  logic                    tr_valid;
  logic [63:0]             tr_nx, tr_ny;
  logic [pti_pkg::D_W-1:0] tr_d;
  pti_pkg::div_meta_t      tr_meta;

  logic                    dv_valid;
  logic [pti_pkg::Q_W-1:0] dv_qx, dv_qy;
  logic                    dv_ovfx, dv_ovfy;
  pti_pkg::div_meta_t      dv_meta;

  logic               sat_x, sat_y;
  logic signed [31:0] fx, fy;

  logic               done_q;
  logic signed [31:0] cos_q, sin_q, sx_q, sy_q;
  logic               sat_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  pti_phase u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .w_i     (angular_rate_i),
    .vx_i    (linear_rate_x_i),
    .vy_i    (linear_rate_y_i),
    .thr_i   (thr_q),
    .valid_o (ph_valid),
    .z_o     (ph_z),
    .meta_o  (ph_meta)
  );

  pti_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ph_valid),
    .z_i     (ph_z),
    .meta_i  (ph_meta),
    .valid_o (cor_valid),
    .x_o     (cor_x),
    .y_o     (cor_y),
    .meta_o  (cor_meta)
  );

  pti_trans u_trans (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cor_valid),
    .x_i     (cor_x),
    .y_i     (cor_y),
    .meta_i  (cor_meta),
    .valid_o (tr_valid),
    .nx_o    (tr_nx),
    .ny_o    (tr_ny),
    .d_o     (tr_d),
    .meta_o  (tr_meta)
  );

  pti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (tr_valid),
    .nx_i    (tr_nx),
    .ny_i    (tr_ny),
    .d_i     (tr_d),
    .meta_i  (tr_meta),
    .valid_o (dv_valid),
    .qx_o    (dv_qx),
    .qy_o    (dv_qy),
    .ovfx_o  (dv_ovfx),
    .ovfy_o  (dv_ovfy),
    .meta_o  (dv_meta)
  );

  // signed quotient with clamp to the 32-bit range
  always_comb begin
    if (!dv_meta.neg_x) begin
      sat_x = dv_ovfx || (dv_qx > 33'h0_7FFF_FFFF);
      fx    = sat_x ? 32'sh7FFF_FFFF : $signed(dv_qx[31:0]);
    end else begin
      sat_x = dv_ovfx || (dv_qx > 33'h0_8000_0000);
      fx    = sat_x ? 32'sh8000_0000 : $signed(~dv_qx[31:0] + 32'd1);
    end
    if (!dv_meta.neg_y) begin
      sat_y = dv_ovfy || (dv_qy > 33'h0_7FFF_FFFF);
      fy    = sat_y ? 32'sh7FFF_FFFF : $signed(dv_qy[31:0]);
    end else begin
      sat_y = dv_ovfy || (dv_qy > 33'h0_8000_0000);
      fy    = sat_y ? 32'sh8000_0000 : $signed(~dv_qy[31:0] + 32'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q <= dv_meta.c;
    sin_q <= dv_meta.s;
    if (dv_meta.zero) begin
      sx_q  <= dv_meta.vx;
      sy_q  <= dv_meta.vy;
      sat_q <= 1'b0;
    end else begin
      sx_q  <= fx;
      sy_q  <= fy;
      sat_q <= sat_x || sat_y;
    end
  end

  assign done_o        = done_q;
  assign cos_heading_o = cos_q;
  assign sin_heading_o = sin_q;
  assign shift_x_o     = sx_q;
  assign shift_y_o     = sy_q;
  assign saturated_o   = sat_q;

  `PTI_ASSERT_DELAY(a_cordic_latency, ph_valid, pti_pkg::CORDIC_STEPS, cor_valid)
  `PTI_ASSERT_IMPL(a_unit_range, done_q, (cos_q <= pti_pkg::ONE_Q30) && (cos_q >= -pti_pkg::ONE_Q30) && (sin_q <= pti_pkg::ONE_Q30) && (sin_q >= -pti_pkg::ONE_Q30))
  `PTI_ASSERT_IMPL(a_sat_clamped, done_q && sat_q, (sx_q == 32'sh7FFF_FFFF) || (sx_q == 32'sh8000_0000) || (sy_q == 32'sh7FFF_FFFF) || (sy_q == 32'sh8000_0000))

endmodule

`default_nettype wire

// ===== hw/rtl/pti_phase.sv =====
// angle reduction: rate to turn fraction, quadrant fold and scaling to q2.30 radians
// depends on pti_pkg
`timescale 1ns / 1ps
`default_nettype none

module pti_phase (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic signed [31:0]    w_i,
  input  logic signed [31:0]    vx_i,
  input  logic signed [31:0]    vy_i,
  input  logic [15:0]           thr_i,
  output logic                  valid_o,
  output logic signed [32:0]    z_o,
  output pti_pkg::cordic_meta_t meta_o
);

  logic [4:0] vld_q;

  logic [31:0] w_u, abs_w;
  logic [63:0] hi_d, lo_d, hi_q, lo_q;
  pti_pkg::cordic_meta_t m1_d, m1_q, m2_q, m3_d, m3_q, m4_q, m5_q;

  logic [63:0] top;
  logic [31:0] ph_d, ph_q;

  logic signed [32:0] pe, pf, pf_neg;
  logic [30:0] ap_d, ap_q;
  logic pn_q, pn4_q;

  logic [61:0] prod_q, rnd;
  logic [32:0] zp;
  logic signed [32:0] z_d, z_q;

  always_comb begin
    w_u   = w_i;
    abs_w = w_u[31] ? (~w_u + 32'd1) : w_u;
    hi_d  = abs_w * pti_pkg::INV_2PI_HI;
    lo_d  = abs_w * pti_pkg::INV_2PI_LO;
    m1_d.zero  = ({16'd0, thr_i} >= abs_w);
    m1_d.flip  = 1'b0;
    m1_d.w_neg = w_u[31];
    m1_d.abs_w = abs_w;
    m1_d.vx    = vx_i;
    m1_d.vy    = vy_i;
  end

  // fractional turn, negated for a negative rate
  always_comb begin
    top  = hi_q + {32'd0, lo_q[63:32]};
    ph_d = top[pti_pkg::FRAC_BITS+31:pti_pkg::FRAC_BITS];
    if (m1_q.w_neg) begin
      ph_d = ~ph_d + 32'd1;
    end
  end

  // fold into [-quarter, quarter] turn
  always_comb begin
    pe   = {ph_q[31], ph_q};
    m3_d = m2_q;
    pf   = pe;
    if (pe > 33'sd1073741824) begin
      pf = pe - 33'sd2147483648;
      m3_d.flip = 1'b1;
    end else if (pe < -33'sd1073741824) begin
      pf = pe + 33'sd2147483648;
      m3_d.flip = 1'b1;
    end
    pf_neg = -pf;
    ap_d   = pf[32] ? pf_neg[30:0] : pf[30:0];
  end

  always_comb begin
    rnd = prod_q + (62'd1 << 29);
    zp  = {1'b0, rnd[61:30]};
    z_d = pn4_q ? $signed(~zp + 33'd1) : $signed(zp);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    m1_q   <= m1_d;
    ph_q   <= ph_d;
    m2_q   <= m1_q;
    ap_q   <= ap_d;
    pn_q   <= pf[32];
    m3_q   <= m3_d;
    prod_q <= 62'(ap_q) * 62'(pti_pkg::HALF_PI_Q30);
    pn4_q  <= pn_q;
    m4_q   <= m3_q;
    z_q    <= z_d;
    m5_q   <= m4_q;
  end

  assign valid_o = vld_q[4];
  assign z_o     = z_q;
  assign meta_o  = m5_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pti_cordic.sv =====
// rotation-mode cordic, one micro-rotation per register stage
// depends on pti_pkg
`timescale 1ns / 1ps
`default_nettype none

module pti_cordic (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic signed [32:0]    z_i,
  input  pti_pkg::cordic_meta_t meta_i,
  output logic                  valid_o,
  output logic signed [33:0]    x_o,
  output logic signed [33:0]    y_o,
  output pti_pkg::cordic_meta_t meta_o
);

  localparam int N = pti_pkg::CORDIC_STEPS;

  logic [N:1] vld_q;
  logic signed [33:0] x_q [1:N];
  logic signed [33:0] y_q [1:N];
  logic signed [32:0] z_q [1:N];
  pti_pkg::cordic_meta_t m_q [1:N];

  for (genvar gi = 0; gi < N; gi++) begin : g_step
    logic signed [33:0] xa, ya, dx, dy;
    logic signed [32:0] za, arc;
    logic va;
    pti_pkg::cordic_meta_t ma;

    if (gi == 0) begin : g_src_in
      assign xa = pti_pkg::CORDIC_GAIN;
      assign ya = '0;
      assign za = z_i;
      assign ma = meta_i;
      assign va = valid_i;
    end else begin : g_src_reg
      assign xa = x_q[gi];
      assign ya = y_q[gi];
      assign za = z_q[gi];
      assign ma = m_q[gi];
      assign va = vld_q[gi];
    end

    assign dx  = ya >>> gi;
    assign dy  = xa >>> gi;
    assign arc = pti_pkg::arc_of(gi);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[gi+1] <= 1'b0;
      end else begin
        vld_q[gi+1] <= va;
      end
    end

    always_ff @(posedge clk_i) begin
      if (!za[32]) begin
        x_q[gi+1] <= xa - dx;
        y_q[gi+1] <= ya + dy;
        z_q[gi+1] <= za - arc;
      end else begin
        x_q[gi+1] <= xa + dx;
        y_q[gi+1] <= ya - dy;
        z_q[gi+1] <= za + arc;
      end
      m_q[gi+1] <= ma;
    end
  end

  assign valid_o = vld_q[N];
  assign x_o     = x_q[N];
  assign y_o     = y_q[N];
  assign meta_o  = m_q[N];

endmodule

`default_nettype wire

// ===== hw/rtl/pti_trans.sv =====
// translation numerators: clamp of cordic results, products, sums and magnitudes
// depends on pti_pkg
`timescale 1ns / 1ps
`default_nettype none

module pti_trans (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic signed [33:0]         x_i,
  input  logic signed [33:0]         y_i,
  input  pti_pkg::cordic_meta_t      meta_i,
  output logic                       valid_o,
  output logic [63:0]                nx_o,
  output logic [63:0]                ny_o,
  output logic [pti_pkg::D_W-1:0]    d_o,
  output pti_pkg::div_meta_t         meta_o
);

  logic [4:0] vld_q;

  logic signed [33:0] xc, yc;
  logic signed [31:0] c_d, s_d, c_q, s_q, cm1_q;
  pti_pkg::cordic_meta_t m1_q, m2_q, m3_q, m4_q, m5_q;
  logic signed [31:0] c2_q, s2_q, c3_q, s3_q, c4_q, s4_q, c5_q, s5_q;

  logic signed [63:0] pa_q, pb_q, pc_q, pd_q;
  logic signed [63:0] sx_q, sy_q, sx_neg, sy_neg;
  logic [63:0] mx_q, my_q, nx_q, ny_q;
  logic ngx_q, ngy_q, ngx5_q, ngy5_q;
  logic [pti_pkg::D_W-1:0] d_q;

  always_comb begin
    xc = x_i;
    yc = y_i;
    if (x_i > pti_pkg::ONE_X) xc = pti_pkg::ONE_X;
    else if (x_i < -pti_pkg::ONE_X) xc = -pti_pkg::ONE_X;
    if (y_i > pti_pkg::ONE_X) yc = pti_pkg::ONE_X;
    else if (y_i < -pti_pkg::ONE_X) yc = -pti_pkg::ONE_X;
    if (meta_i.flip) begin
      xc = -xc;
      yc = -yc;
    end
    c_d = xc[31:0];
    s_d = yc[31:0];
    // identity rotation for a twist without turn
    if (meta_i.zero) begin
      c_d = pti_pkg::ONE_Q30;
      s_d = '0;
    end
  end

  assign sx_neg = -sx_q;
  assign sy_neg = -sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    c_q   <= c_d;
    s_q   <= s_d;
    cm1_q <= c_d - pti_pkg::ONE_Q30;
    m1_q  <= meta_i;

    pa_q <= $signed(m1_q.vx) * s_q;
    pb_q <= $signed(m1_q.vy) * cm1_q;
    pc_q <= $signed(m1_q.vy) * s_q;
    pd_q <= $signed(m1_q.vx) * cm1_q;
    m2_q <= m1_q;
    c2_q <= c_q;
    s2_q <= s_q;

    sx_q <= pa_q + pb_q;
    sy_q <= pc_q - pd_q;
    m3_q <= m2_q;
    c3_q <= c2_q;
    s3_q <= s2_q;

    mx_q  <= sx_q[63] ? sx_neg : sx_q;
    my_q  <= sy_q[63] ? sy_neg : sy_q;
    ngx_q <= sx_q[63] ^ m3_q.w_neg;
    ngy_q <= sy_q[63] ^ m3_q.w_neg;
    m4_q  <= m3_q;
    c4_q  <= c3_q;
    s4_q  <= s3_q;

    // add half the divisor for round to nearest
    nx_q   <= mx_q + (64'(m4_q.abs_w) << (pti_pkg::DIV_SHIFT - 1));
    ny_q   <= my_q + (64'(m4_q.abs_w) << (pti_pkg::DIV_SHIFT - 1));
    d_q    <= pti_pkg::D_W'(m4_q.abs_w) << pti_pkg::DIV_SHIFT;
    ngx5_q <= ngx_q;
    ngy5_q <= ngy_q;
    m5_q   <= m4_q;
    c5_q   <= c4_q;
    s5_q   <= s4_q;
  end

  assign valid_o      = vld_q[4];
  assign nx_o         = nx_q;
  assign ny_o         = ny_q;
  assign d_o          = d_q;
  assign meta_o.zero  = m5_q.zero;
  assign meta_o.neg_x = ngx5_q;
  assign meta_o.neg_y = ngy5_q;
  assign meta_o.c     = c5_q;
  assign meta_o.s     = s5_q;
  assign meta_o.vx    = m5_q.vx;
  assign meta_o.vy    = m5_q.vy;

endmodule

`default_nettype wire

// ===== hw/rtl/pti_div.sv =====
// two-lane pipelined restoring divider, one quotient bit per stage per lane
// depends on pti_pkg
`timescale 1ns / 1ps
`default_nettype none

module pti_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [63:0]             nx_i,
  input  logic [63:0]             ny_i,
  input  logic [pti_pkg::D_W-1:0] d_i,
  input  pti_pkg::div_meta_t      meta_i,
  output logic                    valid_o,
  output logic [pti_pkg::Q_W-1:0] qx_o,
  output logic [pti_pkg::Q_W-1:0] qy_o,
  output logic                    ovfx_o,
  output logic                    ovfy_o,
  output pti_pkg::div_meta_t      meta_o
);

  localparam int QW = pti_pkg::Q_W;
  localparam int DW = pti_pkg::D_W;

  logic [QW:0] vld_q;
  logic [DW-1:0] d_q [0:QW];
  pti_pkg::div_meta_t m_q [0:QW];
  logic [DW-1:0] rem_q [0:QW][0:1];
  logic [QW-1:0] nlo_q [0:QW][0:1];
  logic [QW-1:0] q_q   [0:QW][0:1];
  logic          ovf_q [0:QW][0:1];
  logic [63:0]   n_in  [0:1];

  assign n_in[0] = nx_i;
  assign n_in[1] = ny_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    d_q[0] <= d_i;
    m_q[0] <= meta_i;
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane_in
    // quotient at or above 2^QW means the result saturates anyway
    always_ff @(posedge clk_i) begin
      rem_q[0][l] <= DW'(n_in[l] >> QW);
      ovf_q[0][l] <= (DW'(n_in[l] >> QW) >= d_i);
      nlo_q[0][l] <= n_in[l][QW-1:0];
      q_q[0][l]   <= '0;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_stage
    always_ff @(posedge clk_i) begin
      d_q[j] <= d_q[j-1];
      m_q[j] <= m_q[j-1];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      localparam int B = QW - j;
      logic [DW:0] sh;
      logic ge;

      assign sh = {rem_q[j-1][l], nlo_q[j-1][l][B]};
      assign ge = (sh >= {1'b0, d_q[j-1]});

      always_ff @(posedge clk_i) begin
        rem_q[j][l] <= ge ? DW'(sh - {1'b0, d_q[j-1]}) : sh[DW-1:0];
        nlo_q[j][l] <= nlo_q[j-1][l];
        q_q[j][l]   <= q_q[j-1][l] | (ge ? (QW'(1) << B) : QW'(0));
        ovf_q[j][l] <= ovf_q[j-1][l];
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign qx_o    = q_q[QW][0];
  assign qy_o    = q_q[QW][1];
  assign ovfx_o  = ovf_q[QW][0];
  assign ovfy_o  = ovf_q[QW][1];
  assign meta_o  = m_q[QW];

endmodule

`default_nettype wire
